// ===== hdl/hhsp_pkg.sv =====
package hhsp_pkg;

   localparam int MAX_MESSAGE_BYTES = 65536;
   localparam int OFS_W = $clog2(MAX_MESSAGE_BYTES + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] KIND_METHOD  = 3'd0;
   localparam logic [2:0] KIND_TARGET  = 3'd1;
   localparam logic [2:0] KIND_REASON  = 3'd2;
   localparam logic [2:0] KIND_NAME    = 3'd3;
   localparam logic [2:0] KIND_VALUE   = 3'd4;
   localparam logic [2:0] KIND_BODY    = 3'd5;
   localparam logic [2:0] KIND_SUMMARY = 3'd6;

   localparam logic [1:0] OUTCOME_SUCCESS  = 2'd0;
   localparam logic [1:0] OUTCOME_PARSE    = 2'd1;
   localparam logic [1:0] OUTCOME_TOO_LONG = 2'd2;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       end_of_message;
      logic       mode;
   } req_type;

   typedef struct packed {
      logic [2:0]  field_kind;
      logic [15:0] span_start;
      logic [16:0] span_end;
      logic [1:0]  outcome;
      logic [6:0]  version_code;
      logic [9:0]  status_code;
      logic        conn_persist;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       count;
      rsp_type [2:0]    slot;
   } rq_entry_type;

endpackage

// ===== hdl/hhsp_front.sv =====
module hhsp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hhsp_pkg::req_type     req_data,
   input  logic                  queue_full,
   output logic                  push,
   output hhsp_pkg::rq_entry_type push_entry
);

   localparam int OW = hhsp_pkg::OFS_W;
   localparam logic [OW-1:0] MAX_OFS = OW'(hhsp_pkg::MAX_MESSAGE_BYTES);
   localparam logic [3:0] MISMATCH = 4'd15;
   localparam logic [3:0] CONN_LEN = 4'd10;
   localparam logic [3:0] KEEP_LEN = 4'd10;
   localparam logic [3:0] CLOSE_LEN = 4'd5;
   localparam logic [3:0] PROTO_LEN = 4'd5;
   localparam logic [3:0] VERSION_LEN = 4'd8;
   localparam logic [3:0] STATUS_LEN = 4'd3;
   localparam logic [79:0] CONN_TXT = "connection";
   localparam logic [79:0] KEEP_TXT = "keep-alive";
   localparam logic [79:0] CLOSE_TXT = {"close", 40'h0};
   localparam logic [79:0] PROTO_TXT = {"HTTP/", 40'h0};
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [1:0] VERDICT_NONE = 2'd0;
   localparam logic [1:0] VERDICT_KEEP = 2'd1;
   localparam logic [1:0] VERDICT_CLOSE = 2'd2;
   localparam logic [1:0] VERDICT_OTHER = 2'd3;

   typedef enum logic [6:0] {
      PH_SL1    = 7'b0000001,
      PH_SL2    = 7'b0000010,
      PH_SL3    = 7'b0000100,
      PH_HSTART = 7'b0001000,
      PH_HNAME  = 7'b0010000,
      PH_HVALUE = 7'b0100000,
      PH_BODY   = 7'b1000000
   } phase_type;

   typedef struct packed {
      phase_type      ph;
      logic [OW-1:0]  ofs;
      logic [OW-1:0]  ffn;
      logic [OW-1:0]  fln;
      logic           lbp;
      logic [3:0]     tci;
      logic [6:0]     ver;
      logic [9:0]     sta;
      logic [3:0]     nmp;
      logic [3:0]     vmp;
      logic           vclose;
      logic [1:0]     verdict;
      logic [1:0]     err;
      logic           lmode;
   } pst_type;

   typedef struct packed {
      pst_type        st;
      logic           hit;
      logic [OW-1:0]  s;
      logic [OW-1:0]  e;
   } feed_type;

   pst_type state_ff, state_in;
   logic [1:0] count_in;
   hhsp_pkg::rsp_type [2:0] slot_in;

   function automatic logic [7:0] pick(input logic [79:0] txt, input logic [3:0] k);
      logic [7:0] r;
      r = 8'h00;
      if (k < 4'd10) r = txt[8 * (9 - int'(k)) +: 8];
      return r;
   endfunction

   function automatic logic [7:0] lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic pst_type fail(input pst_type s, input logic [1:0] code);
      pst_type r;
      r = s;
      if (s.err == hhsp_pkg::OUTCOME_SUCCESS) r.err = code;
      return r;
   endfunction

   function automatic pst_type clear_state();
      pst_type r;
      r = '0;
      r.ph = PH_SL1;
      return r;
   endfunction

   function automatic pst_type new_line(input pst_type s);
      pst_type r;
      r = s;
      r.ph = PH_HSTART;
      r.ffn = '0;
      r.fln = '0;
      r.nmp = 4'd0;
      r.vmp = 4'd0;
      return r;
   endfunction

   function automatic hhsp_pkg::rsp_type mk(input logic [2:0] kind, input logic [OW-1:0] s,
         input logic [OW-1:0] e, input logic [1:0] oc, input logic [6:0] ver,
         input logic [9:0] st, input logic ka);
      hhsp_pkg::rsp_type r;
      r.field_kind = kind;
      r.span_start = 16'(s);
      r.span_end = 17'(e);
      r.outcome = oc;
      r.version_code = ver;
      r.status_code = st;
      r.conn_persist = ka;
      r.run_last = 1'b0;
      return r;
   endfunction

   function automatic pst_type version_char(input pst_type s, input logic [7:0] c);
      pst_type r;
      logic ok;
      r = s;
      ok = 1'b1;
      if (s.tci < PROTO_LEN) begin
         ok = (c == pick(PROTO_TXT, s.tci));
      end else if (s.tci == 4'd5) begin
         ok = is_digit(c);
         if (ok) r.ver = 7'((c - 8'h30) * 8'd10);
      end else if (s.tci == 4'd6) begin
         ok = (c == ".");
      end else if (s.tci == 4'd7) begin
         ok = is_digit(c);
         if (ok) r.ver = s.ver + 7'(c - 8'h30);
      end
      if (!ok) r = fail(r, hhsp_pkg::OUTCOME_PARSE);
      else if (s.tci < VERSION_LEN) r.tci = s.tci + 4'd1;
      return r;
   endfunction

   function automatic pst_type track(input pst_type s, input logic [7:0] c,
         input logic [OW-1:0] pos, input logic is_name);
      pst_type r;
      logic gap;
      logic [7:0] lc;
      r = s;
      lc = lower(c);
      gap = 1'b0;
      if (!(c == " " || c == CH_TAB)) begin
         gap = (s.fln != '0) && (s.fln != pos);
         if (s.fln == '0) r.ffn = pos;
         r.fln = pos + 1'b1;
         if (is_name) begin
            if (s.nmp != MISMATCH)
               r.nmp = (gap || s.nmp >= CONN_LEN || lc != pick(CONN_TXT, s.nmp)) ?
                       MISMATCH : s.nmp + 4'd1;
         end else if (s.vmp != MISMATCH) begin
            if (s.vmp == 4'd0) begin
               if (lc == "k") begin
                  r.vclose = 1'b0;
                  r.vmp = 4'd1;
               end else if (lc == "c") begin
                  r.vclose = 1'b1;
                  r.vmp = 4'd1;
               end else begin
                  r.vmp = MISMATCH;
               end
            end else if (s.vclose) begin
               r.vmp = (gap || s.vmp >= CLOSE_LEN || lc != pick(CLOSE_TXT, s.vmp)) ?
                       MISMATCH : s.vmp + 4'd1;
            end else begin
               r.vmp = (gap || s.vmp >= KEEP_LEN || lc != pick(KEEP_TXT, s.vmp)) ?
                       MISMATCH : s.vmp + 4'd1;
            end
         end
      end
      return r;
   endfunction

   function automatic feed_type feed(input pst_type s, input logic [7:0] c,
         input logic [OW-1:0] pos);
      feed_type f;
      f.st = s;
      f.hit = 1'b0;
      f.s = '0;
      f.e = '0;
      case (s.ph)
         PH_SL1: begin
            if (!s.lmode) begin
               if (c == " ") begin
                  f.st.ffn = pos;
                  f.st.ph = PH_SL2;
               end
            end else if (c == " ") begin
               if (s.tci < VERSION_LEN) begin
                  f.st = fail(s, hhsp_pkg::OUTCOME_PARSE);
               end else begin
                  f.st.ph = PH_SL2;
                  f.st.tci = 4'd0;
               end
            end else begin
               f.st = version_char(s, c);
            end
         end
         PH_SL2: begin
            if (!s.lmode) begin
               if (c == " ") begin
                  f.st.fln = pos;
                  f.st.ph = PH_SL3;
                  f.st.tci = 4'd0;
               end
            end else if (c == " ") begin
               if (s.tci != STATUS_LEN) begin
                  f.st = fail(s, hhsp_pkg::OUTCOME_PARSE);
               end else begin
                  f.st.fln = pos;
                  f.st.ph = PH_SL3;
               end
            end else if (is_digit(c) && s.tci < STATUS_LEN) begin
               f.st.sta = s.sta * 10'd10 + {2'b00, c - 8'h30};
               f.st.tci = s.tci + 4'd1;
            end else begin
               f.st = fail(s, hhsp_pkg::OUTCOME_PARSE);
            end
         end
         PH_SL3: begin
            if (!s.lmode) f.st = version_char(s, c);
         end
         PH_HSTART, PH_HNAME: begin
            f.st.ph = PH_HNAME;
            if (c == ":") begin
               if (s.fln == '0) begin
                  f.st = fail(f.st, hhsp_pkg::OUTCOME_PARSE);
               end else begin
                  f.hit = 1'b1;
                  f.s = s.ffn;
                  f.e = s.fln;
                  f.st.ph = PH_HVALUE;
                  f.st.ffn = '0;
                  f.st.fln = '0;
                  f.st.vmp = 4'd0;
               end
            end else begin
               f.st = track(f.st, c, pos, 1'b1);
            end
         end
         PH_HVALUE: begin
            f.st = track(s, c, pos, 1'b0);
         end
         default: begin
         end
      endcase
      return f;
   endfunction

   always_comb begin : step_logic
      pst_type s;
      feed_type f;
      logic [OW-1:0] pos;
      logic [OW-1:0] cr;
      logic [7:0] c;
      logic done;
      logic whole;
      logic ka;
      logic [1:0] n;
      hhsp_pkg::rsp_type [2:0] slot;
      s = state_ff;
      c = req_data.msg_byte;
      pos = state_ff.ofs;
      cr = pos - 1'b1;
      done = 1'b0;
      whole = 1'b0;
      ka = 1'b0;
      n = 2'd0;
      slot = '0;
      f = '0;
      if (pos == '0) s.lmode = req_data.mode;
      if (s.err == hhsp_pkg::OUTCOME_SUCCESS) begin
         if (pos >= MAX_OFS) begin
            s = fail(s, hhsp_pkg::OUTCOME_TOO_LONG);
         end else if (s.ph != PH_BODY) begin
            if (s.lbp) begin
               s.lbp = 1'b0;
               if (c == CH_LF) begin
                  done = 1'b1;
                  case (s.ph)
                     PH_SL3: begin
                        if (!s.lmode) begin
                           if (s.tci < VERSION_LEN) begin
                              s = fail(s, hhsp_pkg::OUTCOME_PARSE);
                           end else begin
                              slot[n] = mk(hhsp_pkg::KIND_METHOD, '0, s.ffn,
                                           2'd0, 7'd0, 10'd0, 1'b0);
                              n = n + 2'd1;
                              slot[n] = mk(hhsp_pkg::KIND_TARGET, s.ffn + 1'b1, s.fln,
                                           2'd0, 7'd0, 10'd0, 1'b0);
                              n = n + 2'd1;
                              s = new_line(s);
                           end
                        end else begin
                           slot[n] = mk(hhsp_pkg::KIND_REASON, s.fln + 1'b1, cr,
                                        2'd0, 7'd0, 10'd0, 1'b0);
                           n = n + 2'd1;
                           s = new_line(s);
                        end
                     end
                     PH_HSTART: begin
                        s.ph = PH_BODY;
                        s.ffn = cr + 2'd2;
                     end
                     PH_HVALUE: begin
                        if (s.fln == '0)
                           slot[n] = mk(hhsp_pkg::KIND_VALUE, cr, cr,
                                        2'd0, 7'd0, 10'd0, 1'b0);
                        else
                           slot[n] = mk(hhsp_pkg::KIND_VALUE, s.ffn, s.fln,
                                        2'd0, 7'd0, 10'd0, 1'b0);
                        n = n + 2'd1;
                        if (s.nmp == CONN_LEN) begin
                           whole = (s.vmp == (s.vclose ? CLOSE_LEN : KEEP_LEN));
                           if (s.fln == '0) s.verdict = VERDICT_NONE;
                           else if (whole) s.verdict = s.vclose ? VERDICT_CLOSE : VERDICT_KEEP;
                           else s.verdict = VERDICT_OTHER;
                        end
                        s = new_line(s);
                     end
                     default: begin
                        s = fail(s, hhsp_pkg::OUTCOME_PARSE);
                     end
                  endcase
               end else begin
                  f = feed(s, CH_CR, cr);
                  s = f.st;
                  if (s.err != hhsp_pkg::OUTCOME_SUCCESS) done = 1'b1;
               end
            end
            if (!done) begin
               if (c == CH_CR) begin
                  s.lbp = 1'b1;
               end else begin
                  f = feed(s, c, pos);
                  s = f.st;
                  if (f.hit) begin
                     slot[n] = mk(hhsp_pkg::KIND_NAME, f.s, f.e, 2'd0, 7'd0, 10'd0, 1'b0);
                     n = n + 2'd1;
                  end
               end
            end
         end
      end
      if (s.ofs < MAX_OFS) s.ofs = s.ofs + 1'b1;
      if (req_data.end_of_message) begin
         if (s.err == hhsp_pkg::OUTCOME_SUCCESS && s.ph != PH_BODY)
            s = fail(s, hhsp_pkg::OUTCOME_PARSE);
         if (s.err == hhsp_pkg::OUTCOME_SUCCESS && s.ofs > s.ffn) begin
            slot[n] = mk(hhsp_pkg::KIND_BODY, s.ffn, s.ofs, 2'd0, 7'd0, 10'd0, 1'b0);
            n = n + 2'd1;
         end
         if (s.err == hhsp_pkg::OUTCOME_SUCCESS) begin
            if (s.verdict == VERDICT_KEEP) ka = 1'b1;
            else if (s.verdict == VERDICT_NONE) ka = (s.ver == 7'd11);
            else ka = 1'b0;
            slot[n] = mk(hhsp_pkg::KIND_SUMMARY, '0, '0, hhsp_pkg::OUTCOME_SUCCESS, s.ver,
                         s.lmode ? s.sta : 10'd0, ka);
         end else begin
            slot[n] = mk(hhsp_pkg::KIND_SUMMARY, '0, '0, s.err, 7'd0, 10'd0, 1'b0);
         end
         n = n + 2'd1;
         s = clear_state();
      end
      state_in = s;
      count_in = n;
      slot_in = slot;
   end

   assign req_ready = !queue_full;
   assign push = req_valid && req_ready && (count_in != 2'd0);
   assign push_entry.count = count_in;
   assign push_entry.slot = slot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clear_state();
      end else if (req_valid && req_ready) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/hhsp_queue.sv =====
module hhsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hhsp_pkg::rq_entry_type push_entry,
   input  logic                   pop,
   output logic                   full,
   output logic                   empty,
   output hhsp_pkg::rq_entry_type head
);

   localparam int AW = hhsp_pkg::QUEUE_AW;
   localparam logic [AW:0] DEPTH = (AW + 1)'(hhsp_pkg::QUEUE_DEPTH);

   hhsp_pkg::rq_entry_type mem_ff [hhsp_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == DEPTH);
   assign empty = (cnt_ff == '0);
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("Queue written while full.");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("Queue read while empty.");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= DEPTH)
      else $error("Queue fill count out of range.");
   assert property (@(posedge clock) disable iff (reset) (push && !pop) |=> !empty)
      else $error("Queue lost an entry.");
`endif

endmodule

// ===== hdl/hhsp_back.sv =====
module hhsp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  hhsp_pkg::rq_entry_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output hhsp_pkg::rsp_type      rsp_data
);

   logic [1:0] sub_ff, sub_in;
   logic valid_ff, valid_in;
   hhsp_pkg::rsp_type data_ff, data_in;
   logic tail;

   always_comb begin
      pop = 1'b0;
      sub_in = sub_ff;
      valid_in = valid_ff;
      data_in = data_ff;
      tail = (sub_ff == head.count - 2'd1);
      if (!valid_ff || rsp_ready) begin
         valid_in = !empty;
         if (!empty) begin
            data_in = head.slot[sub_ff];
            data_in.run_last = tail;
            if (tail) begin
               pop = 1'b1;
               sub_in = 2'd0;
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

// ===== hdl/http_header_stream_parser.sv =====
// The block parses an HTTP/1.x message that arrives one byte per beat on the
// req_ channel, with the request or response mode taken from the first beat.
// Each beat may cause zero to three result beats on the rsp_ channel: spans
// for the start line fields, header names and values, the body, and a
// summary on the beat marked as the end of the message. The final result of
// each input beat carries run_last.
// One input beat is accepted every cycle while the result queue has room.
// The results of an accepted beat are written into the queue and then pass
// through the output register, leaving at one per cycle while the receiver
// is ready. The four-entry queue between the parser and the output stage
// holds the results of up to four input beats, so a stalled receiver stops
// input only once the queue fills. Reset clears the parser to the start of a
// message and empties the queue and output register.
module http_header_stream_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hhsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hhsp_pkg::rsp_type rsp_data
);

   logic push, pop, full, empty;
   hhsp_pkg::rq_entry_type push_entry, head;

   hhsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   hhsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   hhsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== tb/http_header_stream_parser_test.sv =====
`timescale 1ns / 100ps

module http_header_stream_parser_test;

   localparam int PH_LINE_FIRST = 0;
   localparam int PH_LINE_SECOND = 1;
   localparam int PH_LINE_THIRD = 2;
   localparam int PH_HEAD_START = 3;
   localparam int PH_HEAD_NAME = 4;
   localparam int PH_HEAD_VALUE = 5;
   localparam int PH_BODY = 6;
   localparam int NO_MATCH = 15;
   localparam int VERDICT_NONE = 0;
   localparam int VERDICT_KEEP = 1;
   localparam int VERDICT_CLOSE = 2;
   localparam int VERDICT_OTHER = 3;
   localparam logic MODE_REQUEST = 1'b0;
   localparam logic MODE_RESPONSE = 1'b1;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   hhsp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   hhsp_pkg::rsp_type rsp_data;

   int      phase, offset, first_nb, last_nb, cr_pending, char_index;
   int      version_acc, status_acc, name_prog, value_prog, verdict, err_code;
   bit      value_close;
   logic    msg_mode;
   hhsp_pkg::rsp_type step_out[$];
   hhsp_pkg::rsp_type pending_rsp[$];
   int      failures;

   typedef struct {
      string             text;
      logic              mode;
      bit                check_summary;
      hhsp_pkg::rsp_type summary;
   } directed_row_type;

   directed_row_type rows[$];

   http_header_stream_parser i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int to_lower(int c);
      return (c >= "A" && c <= "Z") ? c + 32 : c;
   endfunction

   function automatic bit is_digit(int c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void parser_clear();
      phase = PH_LINE_FIRST; offset = 0; first_nb = 0; last_nb = 0;
      cr_pending = 0; char_index = 0; version_acc = 0; status_acc = 0;
      name_prog = 0; value_prog = 0; value_close = 0; verdict = VERDICT_NONE;
      err_code = 0; msg_mode = MODE_REQUEST;
   endfunction

   function automatic void flag_error(int code);
      if (err_code == 0) err_code = code;
   endfunction

   function automatic void push_span(logic [2:0] kind, int s, int e);
      hhsp_pkg::rsp_type r;
      r = '0;
      r.field_kind = kind;
      r.span_start = s[15:0];
      r.span_end = e[16:0];
      if (step_out.size() < 3) step_out.push_back(r);
   endfunction

   function automatic void version_byte(int c);
      string proto;
      proto = "HTTP/";
      if (char_index < 5) begin
         if (c != proto[char_index]) begin
            flag_error(hhsp_pkg::OUTCOME_PARSE);
            return;
         end
      end else if (char_index == 5) begin
         if (!is_digit(c)) begin
            flag_error(hhsp_pkg::OUTCOME_PARSE);
            return;
         end
         version_acc = (c - "0") * 10;
      end else if (char_index == 6) begin
         if (c != ".") begin
            flag_error(hhsp_pkg::OUTCOME_PARSE);
            return;
         end
      end else if (char_index == 7) begin
         if (!is_digit(c)) begin
            flag_error(hhsp_pkg::OUTCOME_PARSE);
            return;
         end
         version_acc += c - "0";
      end
      if (char_index < 8) char_index++;
   endfunction

   function automatic void track_byte(int c, int pos, bit is_name);
      string conn_word, keep_word, close_word;
      bit    gap;
      int    lc;
      conn_word = "connection";
      keep_word = "keep-alive";
      close_word = "close";
      lc = to_lower(c);
      if (c == " " || c == "\t") return;
      gap = last_nb != 0 && last_nb != pos;
      if (last_nb == 0) first_nb = pos;
      last_nb = pos + 1;
      if (is_name) begin
         if (name_prog == NO_MATCH) return;
         name_prog = (gap || name_prog >= 10 || lc != conn_word[name_prog]) ?
                     NO_MATCH : name_prog + 1;
         return;
      end
      if (value_prog == NO_MATCH) return;
      if (value_prog == 0) begin
         if (lc == "k") begin
            value_close = 0;
            value_prog = 1;
         end else if (lc == "c") begin
            value_close = 1;
            value_prog = 1;
         end else begin
            value_prog = NO_MATCH;
         end
      end else if (value_close) begin
         value_prog = (gap || value_prog >= 5 || lc != close_word[value_prog]) ?
                      NO_MATCH : value_prog + 1;
      end else begin
         value_prog = (gap || value_prog >= 10 || lc != keep_word[value_prog]) ?
                      NO_MATCH : value_prog + 1;
      end
   endfunction

   function automatic void line_byte(int c, int pos);
      bit resp;
      resp = msg_mode == MODE_RESPONSE;
      case (phase)
         PH_LINE_FIRST: begin
            if (!resp) begin
               if (c == " ") begin
                  first_nb = pos;
                  phase = PH_LINE_SECOND;
               end
            end else if (c == " ") begin
               if (char_index < 8) flag_error(hhsp_pkg::OUTCOME_PARSE);
               else begin
                  phase = PH_LINE_SECOND;
                  char_index = 0;
               end
            end else begin
               version_byte(c);
            end
         end
         PH_LINE_SECOND: begin
            if (!resp) begin
               if (c == " ") begin
                  last_nb = pos;
                  phase = PH_LINE_THIRD;
                  char_index = 0;
               end
            end else if (c == " ") begin
               if (char_index != 3) flag_error(hhsp_pkg::OUTCOME_PARSE);
               else begin
                  last_nb = pos;
                  phase = PH_LINE_THIRD;
               end
            end else if (is_digit(c) && char_index < 3) begin
               status_acc = status_acc * 10 + (c - "0");
               char_index++;
            end else begin
               flag_error(hhsp_pkg::OUTCOME_PARSE);
            end
         end
         PH_LINE_THIRD: begin
            if (!resp) version_byte(c);
         end
         PH_HEAD_START, PH_HEAD_NAME: begin
            phase = PH_HEAD_NAME;
            if (c == ":") begin
               if (last_nb == 0) begin
                  flag_error(hhsp_pkg::OUTCOME_PARSE);
                  return;
               end
               push_span(hhsp_pkg::KIND_NAME, first_nb, last_nb);
               phase = PH_HEAD_VALUE;
               first_nb = 0;
               last_nb = 0;
               value_prog = 0;
            end else begin
               track_byte(c, pos, 1);
            end
         end
         PH_HEAD_VALUE: track_byte(c, pos, 0);
         default: ;
      endcase
   endfunction

   function automatic void next_header_line();
      phase = PH_HEAD_START;
      first_nb = 0;
      last_nb = 0;
      name_prog = 0;
      value_prog = 0;
   endfunction

   function automatic void line_done(int cr);
      case (phase)
         PH_LINE_THIRD: begin
            if (msg_mode == MODE_REQUEST) begin
               if (char_index < 8) begin
                  flag_error(hhsp_pkg::OUTCOME_PARSE);
                  return;
               end
               push_span(hhsp_pkg::KIND_METHOD, 0, first_nb);
               push_span(hhsp_pkg::KIND_TARGET, first_nb + 1, last_nb);
            end else begin
               push_span(hhsp_pkg::KIND_REASON, last_nb + 1, cr);
            end
            next_header_line();
         end
         PH_HEAD_START: begin
            phase = PH_BODY;
            first_nb = cr + 2;
         end
         PH_HEAD_VALUE: begin
            if (last_nb == 0) push_span(hhsp_pkg::KIND_VALUE, cr, cr);
            else push_span(hhsp_pkg::KIND_VALUE, first_nb, last_nb);
            if (name_prog == 10) begin
               if (last_nb == 0) verdict = VERDICT_NONE;
               else if (value_prog == (value_close ? 5 : 10))
                  verdict = value_close ? VERDICT_CLOSE : VERDICT_KEEP;
               else verdict = VERDICT_OTHER;
            end
            next_header_line();
         end
         default: flag_error(hhsp_pkg::OUTCOME_PARSE);
      endcase
   endfunction

   // Works out the results of one beat and appends them to pending_rsp.
   function automatic void parse_beat(hhsp_pkg::req_type beat);
      int                pos, c;
      hhsp_pkg::rsp_type r;
      pos = offset;
      c = beat.msg_byte;
      step_out.delete();
      if (pos == 0) msg_mode = beat.mode;
      if (err_code == 0) begin
         if (pos >= hhsp_pkg::MAX_MESSAGE_BYTES) flag_error(hhsp_pkg::OUTCOME_TOO_LONG);
         else if (phase != PH_BODY) begin
            if (cr_pending != 0) begin
               cr_pending = 0;
               if (c == "\n") begin
                  line_done(pos - 1);
                  c = -1;
               end else begin
                  line_byte("\r", pos - 1);
                  if (err_code != 0) c = -1;
               end
            end
            if (c == "\r") cr_pending = 1;
            else if (c >= 0) line_byte(c, pos);
         end
      end
      if (offset < hhsp_pkg::MAX_MESSAGE_BYTES) offset++;
      if (beat.end_of_message) begin
         if (err_code == 0 && phase != PH_BODY) flag_error(hhsp_pkg::OUTCOME_PARSE);
         if (err_code == 0 && offset > first_nb)
            push_span(hhsp_pkg::KIND_BODY, first_nb, offset);
         r = '0;
         r.field_kind = hhsp_pkg::KIND_SUMMARY;
         r.outcome = err_code[1:0];
         if (err_code == 0) begin
            r.version_code = version_acc[6:0];
            r.status_code = (msg_mode == MODE_RESPONSE) ? status_acc[9:0] : '0;
            if (verdict == VERDICT_KEEP) r.conn_persist = 1'b1;
            else if (verdict == VERDICT_NONE) r.conn_persist = version_acc == 11;
         end
         if (step_out.size() < 3) step_out.push_back(r);
         parser_clear();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
      foreach (step_out[i]) pending_rsp.push_back(step_out[i]);
   endfunction

   task automatic send_beat(logic [7:0] b, logic eom, logic m);
      if ($urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{msg_byte: b, end_of_message: eom, mode: m};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_beat('{msg_byte: b, end_of_message: eom, mode: m});
   endtask

   task automatic send_text(string s, logic m);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1, m);
   endtask

   function automatic string random_token(int n, string alphabet);
      string s;
      s = "";
      for (int i = 0; i < n; i++)
         s = {s, string'(alphabet[$urandom_range(0, alphabet.len() - 1)])};
      return s;
   endfunction

   function automatic string random_message(logic m);
      string s, lower_abc, vals[6], names[4];
      lower_abc = "abcdefgXYZ-/";
      vals = '{"keep-alive", "CLOSE", " Keep-Alive\t", "", "kee p-alive", "closed"};
      names = '{"Connection", "connection ", "Host", "X-Y"};
      if (m == MODE_REQUEST)
         s = {random_token($urandom_range(1, 5), "GETPOSU"), " /",
              random_token($urandom_range(0, 6), lower_abc), " HTTP/1.",
              string'(8'("0" + $urandom_range(0, 1))), "\r\n"};
      else
         s = {"HTTP/", string'(8'("0" + $urandom_range(0, 9))), ".",
              string'(8'("0" + $urandom_range(0, 9))), " ",
              random_token(3, "0123456789"), " ",
              random_token($urandom_range(0, 5), "OK nf"), "\r\n"};
      repeat ($urandom_range(0, 3))
         s = {s, names[$urandom_range(0, 3)], ":",
              ($urandom_range(0, 1) ? " " : ""), vals[$urandom_range(0, 5)], "\r\n"};
      s = {s, "\r\n", random_token($urandom_range(0, 4), "ab\r\n")};
      if ($urandom_range(0, 7) == 0) s[$urandom_range(0, s.len() - 1)] = $urandom_range(0, 255);
      return s;
   endfunction

   function automatic void check_summary(int idx, hhsp_pkg::rsp_type exp_r,
                                         hhsp_pkg::rsp_type got_r);
      if (exp_r.field_kind != got_r.field_kind) begin
         $error("row %0d field_kind exp %0d got %0d", idx, exp_r.field_kind,
                got_r.field_kind);
         failures++;
      end
      if (exp_r.outcome != got_r.outcome) begin
         $error("row %0d outcome exp %0d got %0d", idx, exp_r.outcome, got_r.outcome);
         failures++;
      end
      if (exp_r.version_code != got_r.version_code) begin
         $error("row %0d version_code exp %0d got %0d", idx, exp_r.version_code,
                got_r.version_code);
         failures++;
      end
      if (exp_r.status_code != got_r.status_code) begin
         $error("row %0d status_code exp %0d got %0d", idx, exp_r.status_code,
                got_r.status_code);
         failures++;
      end
      if (exp_r.conn_persist != got_r.conn_persist) begin
         $error("row %0d conn_persist exp %0d got %0d", idx, exp_r.conn_persist,
                got_r.conn_persist);
         failures++;
      end
      if (exp_r.run_last != got_r.run_last) begin
         $error("row %0d run_last exp %0d got %0d", idx, exp_r.run_last, got_r.run_last);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected result beat, field_kind %0d", rsp_data.field_kind);
               failures++;
            end else begin
               hhsp_pkg::rsp_type e;
               e = pending_rsp.pop_front();
               if (e.field_kind != rsp_data.field_kind) begin
                  $error("field_kind exp %0d got %0d", e.field_kind, rsp_data.field_kind);
                  failures++;
               end
               if (e.span_start != rsp_data.span_start) begin
                  $error("span_start exp %0d got %0d", e.span_start, rsp_data.span_start);
                  failures++;
               end
               if (e.span_end != rsp_data.span_end) begin
                  $error("span_end exp %0d got %0d", e.span_end, rsp_data.span_end);
                  failures++;
               end
               if (e.outcome != rsp_data.outcome) begin
                  $error("outcome exp %0d got %0d", e.outcome, rsp_data.outcome);
                  failures++;
               end
               if (e.version_code != rsp_data.version_code) begin
                  $error("version_code exp %0d got %0d", e.version_code,
                         rsp_data.version_code);
                  failures++;
               end
               if (e.status_code != rsp_data.status_code) begin
                  $error("status_code exp %0d got %0d", e.status_code, rsp_data.status_code);
                  failures++;
               end
               if (e.conn_persist != rsp_data.conn_persist) begin
                  $error("conn_persist exp %0d got %0d", e.conn_persist,
                         rsp_data.conn_persist);
                  failures++;
               end
               if (e.run_last != rsp_data.run_last) begin
                  $error("run_last exp %0d got %0d", e.run_last, rsp_data.run_last);
                  failures++;
               end
            end
         end
         rsp_ready <= ($time / 400) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic void add_row(string t, logic m, bit chk, logic [1:0] oc,
                                   logic [6:0] ver, logic [9:0] st, logic ka);
      directed_row_type row;
      row.text = t;
      row.mode = m;
      row.check_summary = chk;
      row.summary = '0;
      row.summary.field_kind = hhsp_pkg::KIND_SUMMARY;
      row.summary.outcome = oc;
      row.summary.version_code = ver;
      row.summary.status_code = st;
      row.summary.conn_persist = ka;
      row.summary.run_last = 1'b1;
      rows.push_back(row);
   endfunction

   initial begin
      int sent;
      failures = 0;
      sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      parser_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      add_row("GET / HTTP/1.1\r\n\r\n", MODE_REQUEST, 1, hhsp_pkg::OUTCOME_SUCCESS,
              11, 0, 1);
      add_row("HTTP/1.0 200 OK\r\nConnection: Keep-Alive\r\n\r\nxy", MODE_RESPONSE,
              1, hhsp_pkg::OUTCOME_SUCCESS, 10, 200, 1);
      add_row("HTTP/9.9 999 \r\nconnection:close\r\n\r\n", MODE_RESPONSE,
              1, hhsp_pkg::OUTCOME_SUCCESS, 99, 999, 0);
      add_row("X\r\n", MODE_REQUEST, 1, hhsp_pkg::OUTCOME_PARSE, 0, 0, 0);
      add_row("GET / HTTP/1.1\r\nnocolon\r\n\r\n", MODE_REQUEST, 1,
              hhsp_pkg::OUTCOME_PARSE, 0, 0, 0);
      add_row("HTTP/1.1 20 X\r\n\r\n", MODE_RESPONSE, 1, hhsp_pkg::OUTCOME_PARSE, 0, 0, 0);
      add_row("P /a\rb HTTP/1.1x\r\n : v\r\n", MODE_REQUEST, 0, 0, 0, 0, 0);
      add_row("GET / HTTP/1.1\r\nConnection:\t\r\nConnection: x\r\n\r\n\r\r\n",
              MODE_REQUEST, 0, 0, 0, 0, 0);
      add_row("Q!", MODE_RESPONSE, 1, hhsp_pkg::OUTCOME_PARSE, 0, 0, 0);
      foreach (rows[i]) begin
         send_text(rows[i].text, rows[i].mode);
         sent += rows[i].text.len();
         if (rows[i].check_summary)
            check_summary(i, rows[i].summary, pending_rsp[pending_rsp.size() - 1]);
      end
      while (sent < 230) begin
         logic  m;
         string s;
         m = $urandom_range(0, 1);
         s = random_message(m);
         send_text(s, m);
         sent += s.len();
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
